>>> rtl/u8u16_pkg.sv
`default_nettype none

package u8u16_pkg;

    localparam int ACC_W = 31;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [7:0] LEAD_MIN = 8'hC0;
    localparam logic [7:0] LEAD_MAX = 8'hFD;
    localparam logic [7:0] LEAD_MIN_SHORTEST = 8'hC2;
    localparam logic [5:0] CONT_MASK = 6'h3F;

    typedef struct packed {
        logic [15:0] code_unit;
        logic last;
    } result_t;

    // Surrogates and values of 0xFFFE and above become the replacement character.
    function automatic logic [15:0] fix_value(input logic [ACC_W-1:0] v);
        logic [15:0] r;
        if ((v >= ACC_W'(32'hD800) && v <= ACC_W'(32'hDFFF)) || v >= ACC_W'(32'hFFFE))
        begin
            r = REPLACEMENT;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Control characters below 32 and DEL are dropped.
    function automatic logic keep_value(input logic [15:0] v);
        return (v >= 16'd32) && (v != 16'd127);
    endfunction

endpackage

`default_nettype wire

>>> rtl/utf8_to_utf16_decoder.sv
// Path: a byte that yields a result passes through the input register and then the result
// queue, from whose head the result is offered and taken while out_stall is low.
// Throughput: one byte per cycle while in_stall is low; two results of a byte leave in turn.
// The input register advances into a four-entry result queue whenever that queue
// has room for two results.
// Reset clears the pending sequence, the input register and the result queue.
`default_nettype none

module utf8_to_utf16_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      code_unit,
    output logic             last
);

    logic byte_valid_reg;
    logic byte_valid_next;
    logic [7:0] byte_reg;

    logic [7:0] lead_reg;
    logic [7:0] lead_next;
    logic [2:0] needed_reg;
    logic [2:0] needed_next;
    logic [2:0] received_reg;
    logic [2:0] received_next;
    logic [u8u16_pkg::ACC_W-1:0] acc_reg;
    logic [u8u16_pkg::ACC_W-1:0] acc_next;
    logic bad_reg;
    logic bad_next;

    u8u16_pkg::result_t queue_reg [u8u16_pkg::QUEUE_DEPTH];
    logic [u8u16_pkg::PTR_W-1:0] wr_ptr_reg;
    logic [u8u16_pkg::PTR_W-1:0] wr_ptr_next;
    logic [u8u16_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [u8u16_pkg::PTR_W-1:0] rd_ptr_next;
    logic [u8u16_pkg::CNT_W-1:0] count_reg;
    logic [u8u16_pkg::CNT_W-1:0] count_next;

    logic accept;
    logic advance;
    logic pop;

    logic cand0;
    logic cand1;
    logic [u8u16_pkg::ACC_W-1:0] val0;
    logic [u8u16_pkg::ACC_W-1:0] val1;
    logic [15:0] fix0;
    logic [15:0] fix1;
    logic keep0;
    logic keep1;
    logic [1:0] push_n;
    u8u16_pkg::result_t entry_a;
    u8u16_pkg::result_t entry_b;

    logic is_cont;
    logic overlong;
    logic [2:0] rcv_inc;

    assign accept = in_valid && !in_stall;
    assign advance = byte_valid_reg && (count_reg <= u8u16_pkg::CNT_W'(u8u16_pkg::QUEUE_DEPTH - 2));
    assign in_stall = byte_valid_reg && !advance;
    assign out_valid = (count_reg != '0);
    assign pop = out_valid && !out_stall;
    assign code_unit = queue_reg[rd_ptr_reg].code_unit;
    assign last = queue_reg[rd_ptr_reg].last;

    assign is_cont = (byte_reg[7:6] == 2'b10);
    assign overlong = (lead_reg == 8'hE0 && byte_reg < 8'hA0)
                   || (lead_reg == 8'hF0 && byte_reg < 8'h90)
                   || (lead_reg == 8'hF8 && byte_reg < 8'h88)
                   || (lead_reg == 8'hFC && byte_reg < 8'h84);
    assign rcv_inc = received_reg + 3'd1;

    always_comb
    begin
        lead_next = lead_reg;
        needed_next = needed_reg;
        received_next = received_reg;
        acc_next = acc_reg;
        bad_next = bad_reg;
        cand0 = 1'b0;
        cand1 = 1'b0;
        val0 = u8u16_pkg::ACC_W'(u8u16_pkg::REPLACEMENT);
        val1 = u8u16_pkg::ACC_W'(u8u16_pkg::REPLACEMENT);

        if (needed_reg != 3'd0 && is_cont)
        begin
            bad_next = bad_reg || (received_reg == 3'd0 && overlong);
            acc_next = {acc_reg[u8u16_pkg::ACC_W-7:0], byte_reg[5:0] & u8u16_pkg::CONT_MASK};
            received_next = rcv_inc;
            if (rcv_inc >= needed_reg)
            begin
                cand0 = 1'b1;
                val0 = bad_next ? u8u16_pkg::ACC_W'(u8u16_pkg::REPLACEMENT) : acc_next;
                lead_next = '0;
                needed_next = '0;
                received_next = '0;
                acc_next = '0;
                bad_next = 1'b0;
            end
        end
        else
        begin
            if (needed_reg != 3'd0)
            begin
                cand0 = 1'b1;
                lead_next = '0;
                needed_next = '0;
                received_next = '0;
                acc_next = '0;
                bad_next = 1'b0;
            end
            if (!byte_reg[7])
            begin
                cand1 = 1'b1;
                val1 = u8u16_pkg::ACC_W'(byte_reg);
            end
            else if (byte_reg < u8u16_pkg::LEAD_MIN || byte_reg > u8u16_pkg::LEAD_MAX)
            begin
                cand1 = 1'b1;
            end
            else
            begin
                lead_next = byte_reg;
                received_next = '0;
                bad_next = (byte_reg < u8u16_pkg::LEAD_MIN_SHORTEST);
                if (byte_reg inside {[8'hC0:8'hDF]})
                begin
                    needed_next = 3'd1;
                    acc_next = u8u16_pkg::ACC_W'(byte_reg[4:0]);
                end
                else if (byte_reg inside {[8'hE0:8'hEF]})
                begin
                    needed_next = 3'd2;
                    acc_next = u8u16_pkg::ACC_W'(byte_reg[3:0]);
                end
                else if (byte_reg inside {[8'hF0:8'hF7]})
                begin
                    needed_next = 3'd3;
                    acc_next = u8u16_pkg::ACC_W'(byte_reg[2:0]);
                end
                else if (byte_reg inside {[8'hF8:8'hFB]})
                begin
                    needed_next = 3'd4;
                    acc_next = u8u16_pkg::ACC_W'(byte_reg[1:0]);
                end
                else
                begin
                    needed_next = 3'd5;
                    acc_next = u8u16_pkg::ACC_W'(byte_reg[0]);
                end
            end
        end
    end

    assign fix0 = u8u16_pkg::fix_value(val0);
    assign fix1 = u8u16_pkg::fix_value(val1);
    assign keep0 = cand0 && u8u16_pkg::keep_value(fix0);
    assign keep1 = cand1 && u8u16_pkg::keep_value(fix1);
    assign push_n = advance ? ({1'b0, keep0} + {1'b0, keep1}) : 2'd0;

    always_comb
    begin
        entry_a.code_unit = keep0 ? fix0 : fix1;
        entry_a.last = !(keep0 && keep1);
        entry_b.code_unit = fix1;
        entry_b.last = 1'b1;
    end

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (accept)
        begin
            byte_valid_next = 1'b1;
        end
        else if (advance)
        begin
            byte_valid_next = 1'b0;
        end
        wr_ptr_next = wr_ptr_reg + u8u16_pkg::PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + u8u16_pkg::PTR_W'(pop);
        count_next = count_reg + u8u16_pkg::CNT_W'(push_n) - u8u16_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            lead_reg <= '0;
            needed_reg <= '0;
            received_reg <= '0;
            acc_reg <= '0;
            bad_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            if (advance)
            begin
                lead_reg <= lead_next;
                needed_reg <= needed_next;
                received_reg <= received_next;
                acc_reg <= acc_next;
                bad_reg <= bad_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
        end
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= entry_a;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + u8u16_pkg::PTR_W'(1)] <= entry_b;
        end
    end

endmodule

`default_nettype wire

>>> rtl/u8u16_checker.sv
`default_nettype none

module u8u16_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] code_unit,
    input wire logic        last
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(code_unit) && $stable(last))
        else $error("result payload changed while stalled");

    // Control characters are never delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> code_unit >= 16'd32 && code_unit != 16'd127)
        else $error("control character delivered");

    // Surrogates and the two noncharacters at the top are always replaced.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(code_unit >= 16'hD800 && code_unit <= 16'hDFFF)
            && code_unit < 16'hFFFE)
        else $error("surrogate or noncharacter delivered");

    // A beat that is not the last of its byte is always a replacement character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> code_unit == u8u16_pkg::REPLACEMENT)
        else $error("first of two results is not a replacement character");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (.*);

`default_nettype wire
